@@ design/pip_pkg.sv @@
// pip_pkg: shared codes and types for the point-in-polygon crossing block.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEST   = 2'd2;

  // per-cell control, decoded from the vertex count at the top level
  typedef struct packed {
    logic wr_en;
    logic active;
    logic last;
  } pip_cell_ctl_t;

  // control part of the test token travelling down the chain
  typedef struct packed {
    logic valid;
    logic parity;
  } pip_tok_ctl_t;

endpackage

@@ design/pip_in_if.sv @@
// pip_in_if: valid/ready channel carrying one item (kind, x, y).
// Depends on pip_pkg.
`timescale 1ns / 1ps

interface pip_in_if #(
  parameter int COORD_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic [pip_pkg::KIND_W-1:0]    kind;
  logic signed [COORD_BITS-1:0]  coord_x;
  logic signed [COORD_BITS-1:0]  coord_y;

  modport source (output valid, kind, coord_x, coord_y, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, output ready);
endinterface

@@ design/pip_out_if.sv @@
// pip_out_if: valid/ready channel carrying one result (inside_res, status).
// No dependencies.
`timescale 1ns / 1ps

interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic status;

  modport source (output valid, inside_res, status, input ready);
  modport sink   (input valid, inside_res, status, output ready);
endinterface

@@ design/pip_cell.sv @@
// pip_cell: one vertex register and the edge test from it to the next vertex.
// Two register stages per cell; depends on pip_pkg.
`timescale 1ns / 1ps

module pip_cell #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_pkg::pip_cell_ctl_t        ctl_i,
  input  logic signed [COORD_BITS-1:0]  wr_x_i,
  input  logic signed [COORD_BITS-1:0]  wr_y_i,
  input  logic signed [COORD_BITS-1:0]  v0_x_i,
  input  logic signed [COORD_BITS-1:0]  v0_y_i,
  input  logic signed [COORD_BITS-1:0]  nxt_x_i,
  input  logic signed [COORD_BITS-1:0]  nxt_y_i,
  input  pip_pkg::pip_tok_ctl_t         tok_i,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  output pip_pkg::pip_tok_ctl_t         tok_o,
  output logic signed [COORD_BITS-1:0]  px_o,
  output logic signed [COORD_BITS-1:0]  py_o,
  output logic signed [COORD_BITS-1:0]  x_o,
  output logic signed [COORD_BITS-1:0]  y_o
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic signed [COORD_BITS-1:0] xb, yb;
  logic signed [DW-1:0]         dx_p, dy_p, dx_e, dy_e;
  logic signed [PW-1:0]         p1_d, p2_d;
  logic                         cross_d;

  pip_tok_ctl_t                 s1_tok_q, s2_tok_q;
  logic                         s1_cross_q, s1_dypos_q;
  logic signed [PW-1:0]         s1_p1_q, s1_p2_q;
  logic signed [COORD_BITS-1:0] s1_px_q, s1_py_q, s2_px_q, s2_py_q;
  logic                         hit;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  assign xb = ctl_i.last ? v0_x_i : nxt_x_i;
  assign yb = ctl_i.last ? v0_y_i : nxt_y_i;

  assign dx_p = DW'(px_i) - DW'(x_q);
  assign dy_p = DW'(py_i) - DW'(y_q);
  assign dx_e = DW'(xb) - DW'(x_q);
  assign dy_e = DW'(yb) - DW'(y_q);

  assign p1_d = dx_p * dy_e;
  assign p2_d = dy_p * dx_e;

  assign cross_d = ctl_i.active &&
                   (((y_q <= py_i) && (yb > py_i)) || ((y_q > py_i) && (yb <= py_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tok_q <= '0;
      s2_tok_q <= '0;
    end else begin
      s1_tok_q        <= tok_i;
      s2_tok_q.valid  <= s1_tok_q.valid;
      s2_tok_q.parity <= s1_tok_q.parity ^ (s1_cross_q & hit);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cross_q <= cross_d;
    s1_dypos_q <= dy_e > 0;
    s1_p1_q    <= p1_d;
    s1_p2_q    <= p2_d;
    s1_px_q    <= px_i;
    s1_py_q    <= py_i;
    s2_px_q    <= s1_px_q;
    s2_py_q    <= s1_py_q;
  end

  // compare reversed when the edge runs downward
  assign hit = s1_dypos_q ? (s1_p1_q < s1_p2_q) : (s1_p2_q < s1_p1_q);

  assign tok_o = s2_tok_q;
  assign px_o  = s2_px_q;
  assign py_o  = s2_py_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

@@ design/point_in_polygon_crossing.sv @@
// point_in_polygon_crossing: crossing-number test over a chain of vertex cells.
// Clear, append, unused kind: result registered in the cycle after the transfer.
// Test: result loaded once the token has walked the whole chain, two stages per cell.
// One item in flight; the next transfer is taken once the block is idle and the
// output register is free or being emptied.
// Reset (async, active low) empties the polygon; vertex registers are not reset.
`timescale 1ns / 1ps

module point_in_polygon_crossing #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pip_in_if.sink   in_i,
  pip_out_if.source out_o
);
  import pip_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_vld_q, out_vld_d;
  logic             inside_q, inside_d;
  logic             status_q, status_d;

  logic             xfer, full, do_append, load;

  pip_cell_ctl_t                ctl  [MAX_VERTICES];
  pip_tok_ctl_t                 tok  [MAX_VERTICES+1];
  logic signed [COORD_BITS-1:0] tpx  [MAX_VERTICES+1];
  logic signed [COORD_BITS-1:0] tpy  [MAX_VERTICES+1];
  logic signed [COORD_BITS-1:0] vx   [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy   [MAX_VERTICES];

  assign in_i.ready = (state_q == ST_IDLE) && (!out_vld_q || out_o.ready);
  assign xfer       = in_i.valid && in_i.ready;
  assign full       = count_q == CNT_W'(MAX_VERTICES);
  assign do_append  = xfer && (in_i.kind == KIND_APPEND) && !full;

  assign tok[0].valid  = xfer && (in_i.kind == KIND_TEST);
  assign tok[0].parity = 1'b0;
  assign tpx[0]        = in_i.coord_x;
  assign tpy[0]        = in_i.coord_y;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    assign ctl[i].wr_en  = do_append && (count_q == CNT_W'(i));
    assign ctl[i].active = CNT_W'(i) < count_q;
    assign ctl[i].last   = count_q == CNT_W'(i + 1);

    pip_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[i]),
      .wr_x_i  (in_i.coord_x),
      .wr_y_i  (in_i.coord_y),
      .v0_x_i  (vx[0]),
      .v0_y_i  (vy[0]),
      .nxt_x_i (vx[(i + 1) % MAX_VERTICES]),
      .nxt_y_i (vy[(i + 1) % MAX_VERTICES]),
      .tok_i   (tok[i]),
      .px_i    (tpx[i]),
      .py_i    (tpy[i]),
      .tok_o   (tok[i+1]),
      .px_o    (tpx[i+1]),
      .py_o    (tpy[i+1]),
      .x_o     (vx[i]),
      .y_o     (vy[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    load      = 1'b0;
    inside_d  = inside_q;
    status_d  = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (xfer) begin
          inside_d = 1'b0;
          status_d = 1'b0;
          unique case (in_i.kind)
            KIND_CLEAR: begin
              count_d = '0;
              load    = 1'b1;
            end
            KIND_APPEND: begin
              if (full) begin
                status_d = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
              load = 1'b1;
            end
            KIND_TEST: begin
              state_d = ST_BUSY;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_BUSY: begin
        if (tok[MAX_VERTICES].valid) begin
          inside_d = tok[MAX_VERTICES].parity;
          status_d = 1'b0;
          load     = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
    status_q <= status_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.inside_res = inside_q;
  assign out_o.status     = status_q;

endmodule
